// ----- src/rtttl_melody_parser_macros.svh -----
// Assertion macros for the ringtone parser.
`ifndef RTTTL_MELODY_PARSER_MACROS_SVH
`define RTTTL_MELODY_PARSER_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define RMP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define RMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rmp_pkg.sv -----
// Package with shared types, character codes and the pitch table of the ringtone parser.
`timescale 1ns / 1ps
package rmp_pkg;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } rmp_in_t;

    typedef struct packed {
        logic [15:0] frequency_hz;
        logic [18:0] duration_ms;
        logic [15:0] note_number;
        logic        note_valid;
        logic        last;
    } rmp_out_t;

    typedef enum logic [1:0] {
        CMD_WHOLE = 2'd0,
        CMD_NOTE  = 2'd1,
        CMD_MARK  = 2'd2
    } rmp_cmd_kind_t;

    // One request from the parser to the execution side.
    typedef struct packed {
        rmp_cmd_kind_t kind;
        logic          last;
        logic [15:0]   number;
        logic [15:0]   divisor;
        logic          dotted;
        logic          pause;
        logic [3:0]    pitch_idx;
        logic [16:0]   octave;
    } rmp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rmp_fifo_status_t;

    typedef enum logic [2:0] {
        PH_NAME  = 3'b001,
        PH_HEAD  = 3'b010,
        PH_NOTES = 3'b100
    } rmp_phase_t;

    typedef enum logic [3:0] {
        HS_KEY    = 4'b0001,
        HS_SKIP   = 4'b0010,
        HS_DIGITS = 4'b0100,
        HS_REST   = 4'b1000
    } rmp_head_step_t;

    typedef enum logic [4:0] {
        NS_IDLE  = 5'b00001,
        NS_DUR   = 5'b00010,
        NS_LET   = 5'b00100,
        NS_SHARP = 5'b01000,
        NS_DOT   = 5'b10000
    } rmp_note_step_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_DONE = 3'b100
    } rmp_back_state_t;

    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_LEN  = 2'd1;
    localparam logic [1:0] KEY_OCT  = 2'd2;
    localparam logic [1:0] KEY_BPM  = 2'd3;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CASE_GAP = 8'd32;

    localparam logic [3:0]  PITCH_COUNT    = 4'd12;
    localparam logic [15:0] DEF_LENGTH     = 16'd4;
    localparam logic [15:0] DEF_OCTAVE     = 16'd6;
    localparam logic [15:0] DEF_BPM        = 16'd63;
    localparam logic [15:0] DEF_MAX_NOTES  = 16'd64;
    localparam logic [17:0] WHOLE_DIVIDEND = 18'd240000;
    localparam logic [15:0] FREQ_MAX       = 16'hFFFF;

    // Base frequencies of octave 4, c through b.
    function automatic logic [8:0] rmp_pitch(input logic [3:0] idx);
        logic [8:0] hz;
        unique case (idx)
            4'd0:    hz = 9'd262;
            4'd1:    hz = 9'd277;
            4'd2:    hz = 9'd294;
            4'd3:    hz = 9'd311;
            4'd4:    hz = 9'd330;
            4'd5:    hz = 9'd349;
            4'd6:    hz = 9'd370;
            4'd7:    hz = 9'd392;
            4'd8:    hz = 9'd415;
            4'd9:    hz = 9'd440;
            4'd10:   hz = 9'd466;
            4'd11:   hz = 9'd494;
            default: hz = 9'd0;
        endcase
        return hz;
    endfunction

endpackage

// ----- src/rmp_front.sv -----
// Character parser: walks name, header and notes, and queues requests for the back end.
`timescale 1ns / 1ps
module rmp_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  rmp_pkg::rmp_in_t          s_data,
    input  logic                      cfg_wr_en,
    input  logic [15:0]               cfg_wr_data,
    input  rmp_pkg::rmp_fifo_status_t fifo_status,
    output logic                      push,
    output rmp_pkg::rmp_cmd_t         push_cmd
);
    import rmp_pkg::*;

    rmp_phase_t     phase_reg, phase_next;
    rmp_head_step_t hs_reg, hs_next;
    rmp_note_step_t ns_reg, ns_next;
    logic [1:0]     key_reg, key_next;
    logic [15:0]    def_len_reg, def_len_next;
    logic [15:0]    def_oct_reg, def_oct_next;
    logic [15:0]    bpm_reg, bpm_next;
    logic [15:0]    len_acc_reg, len_acc_next;
    logic [7:0]     letter_reg, letter_next;
    logic           sharp_reg, sharp_next;
    logic           dotted_reg, dotted_next;
    logic [15:0]    notes_reg, notes_next;
    logic [15:0]    max_notes_reg, max_notes_next;

    logic           accept;
    logic [7:0]     c;
    logic           is_dig;
    logic [7:0]     folded;
    logic           below_max;
    logic           sep_req;
    logic           close_req;
    logic [15:0]    close_oct;
    logic           begin_req;
    logic           got;

    function automatic logic [15:0] add_digit(input logic [15:0] v, input logic [3:0] d);
        logic [19:0] t;
        t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {16'd0, d};
        return (t > 20'h0FFFF) ? 16'hFFFF : t[15:0];
    endfunction

    function automatic rmp_cmd_t make_note(
        input logic [7:0]  letter,
        input logic        sharp,
        input logic        dotted,
        input logic [15:0] len_acc,
        input logic [15:0] def_len,
        input logic [15:0] oct,
        input logic [15:0] number
    );
        rmp_cmd_t   r;
        logic [3:0] idx;
        r = '0;
        unique case (letter)
            CH_D:    idx = 4'd2;
            CH_E:    idx = 4'd4;
            CH_F:    idx = 4'd5;
            CH_G:    idx = 4'd7;
            CH_A:    idx = 4'd9;
            CH_B:    idx = 4'd11;
            default: idx = 4'd0;
        endcase
        r.octave = {1'b0, oct};
        if (sharp) begin
            idx = idx + 4'd1;
        end
        // b sharp wraps to c of the next octave
        if (idx == PITCH_COUNT) begin
            idx      = 4'd0;
            r.octave = r.octave + 17'd1;
        end
        r.kind      = CMD_NOTE;
        r.last      = 1'b0;
        r.number    = number;
        r.divisor   = (len_acc != 16'd0) ? len_acc : def_len;
        r.dotted    = dotted;
        r.pause     = (letter == CH_P);
        r.pitch_idx = idx;
        return r;
    endfunction

    assign s_ready = !fifo_status.full;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.text_char;
    assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign folded  = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c + CASE_GAP) : c;
    assign below_max = (notes_reg < max_notes_reg);

    always_comb begin
        phase_next   = phase_reg;
        hs_next      = hs_reg;
        ns_next      = ns_reg;
        key_next     = key_reg;
        def_len_next = def_len_reg;
        def_oct_next = def_oct_reg;
        bpm_next     = bpm_reg;
        len_acc_next = len_acc_reg;
        letter_next  = letter_reg;
        sharp_next   = sharp_reg;
        dotted_next  = dotted_reg;
        notes_next   = notes_reg;
        max_notes_next = cfg_wr_en ? cfg_wr_data : max_notes_reg;
        push      = 1'b0;
        push_cmd  = '0;
        sep_req   = 1'b0;
        close_req = 1'b0;
        close_oct = def_oct_reg;
        begin_req = 1'b0;
        got       = 1'b0;

        if (accept) begin
            unique case (phase_reg)
                PH_NAME: begin
                    if (c == CH_COLON) begin
                        phase_next = PH_HEAD;
                        hs_next    = HS_KEY;
                    end
                end
                PH_HEAD: begin
                    priority if (hs_reg == HS_KEY) begin
                        if ((c == CH_D) || (c == CH_O) || (c == CH_B)) begin
                            hs_next = HS_SKIP;
                            if (c == CH_D) begin
                                key_next     = KEY_LEN;
                                def_len_next = 16'd0;
                            end else if (c == CH_O) begin
                                key_next     = KEY_OCT;
                                def_oct_next = 16'd0;
                            end else begin
                                key_next = KEY_BPM;
                                bpm_next = 16'd0;
                            end
                        end else begin
                            sep_req = 1'b1;
                        end
                    end else if (hs_reg == HS_SKIP) begin
                        hs_next = HS_DIGITS;
                    end else if ((hs_reg == HS_DIGITS) && is_dig) begin
                        unique case (key_reg)
                            KEY_LEN: def_len_next = add_digit(def_len_reg, c[3:0]);
                            KEY_OCT: def_oct_next = add_digit(def_oct_reg, c[3:0]);
                            KEY_BPM: bpm_next     = add_digit(bpm_reg, c[3:0]);
                            default: ;
                        endcase
                    end else if ((hs_reg == HS_DIGITS) || (c == CH_COMMA) ||
                                 (c == CH_COLON)) begin
                        sep_req = 1'b1;
                    end else begin
                        // stray byte after a value: drop
                    end
                    if (sep_req) begin
                        priority if (c == CH_COMMA) begin
                            hs_next = HS_KEY;
                        end else if (c == CH_COLON) begin
                            // whole-note length is divided out by the back end
                            push             = 1'b1;
                            push_cmd.kind    = CMD_WHOLE;
                            push_cmd.divisor = bpm_reg;
                            phase_next       = PH_NOTES;
                            ns_next          = NS_IDLE;
                        end else begin
                            hs_next = HS_REST;
                        end
                    end
                end
                PH_NOTES: begin
                    priority if (ns_reg == NS_IDLE) begin
                        begin_req = 1'b1;
                    end else if (ns_reg == NS_DUR) begin
                        if (is_dig) begin
                            len_acc_next = add_digit(len_acc_reg, c[3:0]);
                        end else begin
                            letter_next = folded;
                            ns_next     = NS_LET;
                        end
                    end else if ((ns_reg == NS_LET) && (c == CH_HASH)) begin
                        sharp_next = 1'b1;
                        ns_next    = NS_SHARP;
                    end else if ((ns_reg != NS_DOT) && (c == CH_DOT)) begin
                        dotted_next = 1'b1;
                        ns_next     = NS_DOT;
                    end else if (is_dig) begin
                        close_req = 1'b1;
                        close_oct = {12'd0, c[3:0]};
                        ns_next   = NS_IDLE;
                    end else begin
                        close_req = 1'b1;
                        begin_req = 1'b1;
                    end
                    // close on the current fields before a new note overwrites them
                    if (close_req && below_max) begin
                        push       = 1'b1;
                        got        = 1'b1;
                        push_cmd   = make_note(letter_reg, sharp_reg, dotted_reg, len_acc_reg,
                                               def_len_reg, close_oct, notes_reg);
                        notes_next = notes_reg + 16'd1;
                    end
                    if (begin_req) begin
                        sharp_next   = 1'b0;
                        dotted_next  = 1'b0;
                        len_acc_next = 16'd0;
                        priority if (c == CH_COMMA) begin
                            ns_next = NS_IDLE;
                        end else if (is_dig) begin
                            len_acc_next = {12'd0, c[3:0]};
                            ns_next      = NS_DUR;
                        end else begin
                            letter_next = folded;
                            ns_next     = NS_LET;
                        end
                    end
                end
                default: ;
            endcase

            if (s_data.end_of_text) begin
                // flush an open note or mark the note just closed as last, else send a bare end marker
                if (!got) begin
                    if ((phase_next == PH_NOTES) && below_max &&
                        ((ns_next == NS_LET) || (ns_next == NS_SHARP) ||
                         (ns_next == NS_DOT))) begin
                        push_cmd   = make_note(letter_next, sharp_next, dotted_next,
                                               len_acc_next, def_len_reg, def_oct_reg,
                                               notes_reg);
                    end else begin
                        push_cmd        = '0;
                        push_cmd.kind   = CMD_MARK;
                        push_cmd.number = notes_reg;
                    end
                end
                push          = 1'b1;
                push_cmd.last = 1'b1;
                phase_next   = PH_NAME;
                hs_next      = HS_KEY;
                ns_next      = NS_IDLE;
                key_next     = KEY_NONE;
                def_len_next = DEF_LENGTH;
                def_oct_next = DEF_OCTAVE;
                bpm_next     = DEF_BPM;
                len_acc_next = 16'd0;
                letter_next  = 8'd0;
                sharp_next   = 1'b0;
                dotted_next  = 1'b0;
                notes_next   = 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_NAME;
            hs_reg        <= HS_KEY;
            ns_reg        <= NS_IDLE;
            key_reg       <= KEY_NONE;
            def_len_reg   <= DEF_LENGTH;
            def_oct_reg   <= DEF_OCTAVE;
            bpm_reg       <= DEF_BPM;
            len_acc_reg   <= 16'd0;
            letter_reg    <= 8'd0;
            sharp_reg     <= 1'b0;
            dotted_reg    <= 1'b0;
            notes_reg     <= 16'd0;
            max_notes_reg <= DEF_MAX_NOTES;
        end else begin
            phase_reg     <= phase_next;
            hs_reg        <= hs_next;
            ns_reg        <= ns_next;
            key_reg       <= key_next;
            def_len_reg   <= def_len_next;
            def_oct_reg   <= def_oct_next;
            bpm_reg       <= bpm_next;
            len_acc_reg   <= len_acc_next;
            letter_reg    <= letter_next;
            sharp_reg     <= sharp_next;
            dotted_reg    <= dotted_next;
            notes_reg     <= notes_next;
            max_notes_reg <= max_notes_next;
        end
    end

endmodule

// ----- src/rmp_cmd_fifo.sv -----
// Short request queue between the parser and the back end.
`timescale 1ns / 1ps
module rmp_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  rmp_pkg::rmp_cmd_t         push_cmd,
    input  logic                      pop,
    output rmp_pkg::rmp_cmd_t         pop_cmd,
    output rmp_pkg::rmp_fifo_status_t status
);
    import rmp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rmp_cmd_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/rmp_back.sv -----
// Back end: bit-serial divider for whole-note and note lengths, pitch shift, result register.
`timescale 1ns / 1ps
module rmp_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rmp_pkg::rmp_fifo_status_t fifo_status,
    input  rmp_pkg::rmp_cmd_t         fifo_cmd,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output rmp_pkg::rmp_out_t         m_data
);
    import rmp_pkg::*;

    rmp_back_state_t state_reg, state_next;
    rmp_cmd_t        cmd_reg, cmd_next;
    logic [17:0]     whole_reg, whole_next;
    logic [17:0]     quot_reg, quot_next;
    logic [15:0]     rem_reg, rem_next;
    logic [17:0]     dvd_reg, dvd_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;
    rmp_out_t        out_reg, out_next;

    logic [16:0]     trial;
    logic            fits;
    logic [18:0]     ms;
    logic [8:0]      base;
    logic [16:0]     shift_up;
    logic [24:0]     wide;
    logic [2:0]      shift_dn;
    logic [15:0]     freq;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign trial = {rem_reg, dvd_reg[17]};
    assign fits  = (trial >= {1'b0, cmd_reg.divisor});
    assign ms    = {1'b0, quot_reg} + (cmd_reg.dotted ? {2'b00, quot_reg[17:1]} : 19'd0);

    // Octave shift around octave 4, saturating upward.
    always_comb begin
        base     = rmp_pitch(cmd_reg.pitch_idx);
        shift_up = cmd_reg.octave - 17'd4;
        wide     = {16'd0, base} << shift_up[3:0];
        shift_dn = 3'd4 - cmd_reg.octave[2:0];
        if (cmd_reg.pause || (cmd_reg.kind != CMD_NOTE)) begin
            freq = 16'd0;
        end else if (cmd_reg.octave >= 17'd4) begin
            if ((shift_up >= 17'd16) || (wide[24:16] != 9'd0)) begin
                freq = FREQ_MAX;
            end else begin
                freq = wide[15:0];
            end
        end else begin
            freq = {7'd0, base >> shift_dn};
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        whole_next   = whole_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        pop          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE: begin
                if (!fifo_status.empty) begin
                    pop      = 1'b1;
                    cmd_next = fifo_cmd;
                    quot_next = 18'd0;
                    rem_next  = 16'd0;
                    dvd_next  = (fifo_cmd.kind == CMD_WHOLE) ? WHOLE_DIVIDEND : whole_reg;
                    cnt_next  = 5'd17;
                    // zero divisor and end markers skip the divider with a zero quotient
                    if ((fifo_cmd.kind == CMD_MARK) || (fifo_cmd.divisor == 16'd0)) begin
                        state_next = BK_DONE;
                    end else begin
                        state_next = BK_DIV;
                    end
                end
            end
            BK_DIV: begin
                quot_next = {quot_reg[16:0], fits};
                rem_next  = fits ? 16'(trial - {1'b0, cmd_reg.divisor}) : trial[15:0];
                dvd_next  = {dvd_reg[16:0], 1'b0};
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (cmd_reg.kind == CMD_WHOLE) begin
                    whole_next = quot_reg;
                    state_next = BK_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    out_next.frequency_hz = freq;
                    out_next.duration_ms  = (cmd_reg.kind == CMD_NOTE) ? ms : 19'd0;
                    out_next.note_number  = cmd_reg.number;
                    out_next.note_valid   = (cmd_reg.kind == CMD_NOTE);
                    out_next.last         = cmd_reg.last;
                    state_next            = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            whole_reg   <= 18'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            whole_reg   <= whole_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- src/rtttl_melody_parser.sv -----
// Throughput: one byte per cycle while the queue has room; each note or tempo request
// holds the back end while its one-bit-per-cycle 18-step divider runs.
// Reset: synchronous, active low; parser state, queue and output valid clear,
// max_notes returns to 64. No clearing pass.
`timescale 1ns / 1ps
`include "rtttl_melody_parser_macros.svh"
module rtttl_melody_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rmp_pkg::rmp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rmp_pkg::rmp_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data
);
    import rmp_pkg::*;

    rmp_fifo_status_t fifo_status;
    logic             push;
    rmp_cmd_t         push_cmd;
    logic             pop;
    rmp_cmd_t         pop_cmd;

    rmp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fifo_status (fifo_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    rmp_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (fifo_status)
    );

    rmp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fifo_status (fifo_status),
        .fifo_cmd    (pop_cmd),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // bare markers only close a string
    `RMP_ASSERT_IMPLIES(a_marker_is_last, m_valid && !m_data.note_valid, m_data.last, "bare marker without last")
    `RMP_ASSERT_IMPLIES(a_marker_zero, m_valid && !m_data.note_valid, (m_data.frequency_hz == 16'd0) && (m_data.duration_ms == 19'd0), "bare marker with nonzero payload")
    `RMP_ASSERT_IMPLIES(a_duration_range, m_valid, m_data.duration_ms <= 19'd360000, "duration out of range")
    // a full queue never takes a request
    `RMP_ASSERT_NEXT(a_full_blocks, fifo_status.full && !pop, !s_ready, "queue full but input ready")

endmodule
